@@ hdl/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and helpers of the trie word and prefix counter.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int NODE_COUNT_DEF = 1024;
    localparam int COUNT_BITS_DEF = 16;
    localparam int ALPHABET_SIZE  = 26;
    localparam int SLOT_W         = 5;
    localparam int OUT_COUNT_W    = 16;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_WORD   = 2'd1,
        CMD_PREFIX = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        FAIL_NONE = 2'd0,
        FAIL_CHAR = 2'd1,
        FAIL_FULL = 2'd2,
        FAIL_MISS = 2'd3
    } t_fail;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CHAR  = 2'd1,
        ST_POOL_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_slot;

    // Fold A-Z and a-z onto 0..25; anything else is not a letter.
    function automatic t_slot letter_slot(input logic [7:0] c);
        t_slot      r;
        logic [7:0] d;
        r.valid = 1'b0;
        r.slot  = '0;
        d       = '0;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d       = c - CH_LOWER_A;
            r.valid = 1'b1;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d       = c - CH_UPPER_A;
            r.valid = 1'b1;
        end
        r.slot = d[SLOT_W-1:0];
        return r;
    endfunction

    function automatic t_status status_of(input t_fail f);
        t_status s;
        unique case (f)
            FAIL_CHAR: s = ST_BAD_CHAR;
            FAIL_FULL: s = ST_POOL_FULL;
            default:   s = ST_OK;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/tpc_if.sv @@
// ----------------------------------------------------------------------------
// tpc_in_if / tpc_out_if
// Valid/ready channels carrying word characters in and count results out.
// ----------------------------------------------------------------------------
interface tpc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] ch;
    logic       has_char;
    logic       last;

    modport source (output valid, output cmd, output ch, output has_char,
                    output last, input ready);
    modport sink   (input valid, input cmd, input ch, input has_char,
                    input last, output ready);
endinterface

interface tpc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] count;
    logic [1:0]  status;

    modport source (output valid, output count, output status, input ready);
    modport sink   (input valid, input count, input status, output ready);
endinterface

@@ hdl/trie_word_and_prefix_counter.sv @@
// ----------------------------------------------------------------------------
// trie_word_and_prefix_counter
// Character trie with per-node pass and end counts in a fixed node pool.
// ----------------------------------------------------------------------------
// After reset the block sweeps its node memories to zero and accepts no
// transaction until done. In each transaction a character walks the trie
// with a read of the node's child row, a step to pick or allocate the link,
// and, for an insert, a read-then-write of the pass count through the
// single-port node memories and the one shared saturating incrementer;
// the first insert item of a word adds a root update, and a last item adds
// the end-count update or result load. The input is not ready while a
// transaction is in work; a finished result waits in the output register.
module trie_word_and_prefix_counter
    import tpc_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpc_in_if.sink    i_in,
    tpc_out_if.source o_out
);

    localparam int IDXW   = $clog2(NODE_COUNT);
    localparam int USEDW  = IDXW + 1;
    localparam int ROWW   = ALPHABET_SIZE * IDXW;
    localparam int EXTW   = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
    localparam logic [IDXW-1:0]  LAST_NODE = IDXW'(NODE_COUNT - 1);
    localparam logic [USEDW-1:0] POOL_SIZE = USEDW'(NODE_COUNT);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_ROOT_WR,
        S_CHAR,
        S_LINK,
        S_PASS_WR,
        S_FINISH,
        S_END_WR,
        S_RESULT
    } t_state;

    t_state                r_state, n_state;
    logic [1:0]            r_cmd, n_cmd;
    logic [7:0]            r_ch, n_ch;
    logic                  r_has, n_has;
    logic                  r_last, n_last;
    logic                  r_started, n_started;
    t_fail                 r_fail, n_fail;
    logic [IDXW-1:0]       r_cur, n_cur;
    logic [USEDW-1:0]      r_used, n_used;
    logic                  r_take, n_take;
    logic [IDXW-1:0]       r_clr, n_clr;
    logic                  r_ovalid, n_ovalid;
    logic [15:0]           r_ocount, n_ocount;
    logic [1:0]            r_ostatus, n_ostatus;

    logic                  child_we, pass_we, end_we;
    logic [IDXW-1:0]       child_addr, pass_addr, end_addr;
    logic [ROWW-1:0]       child_wdata, child_q;
    logic [COUNT_BITS-1:0] pass_wdata, pass_q, end_wdata, end_q;
    logic [COUNT_BITS-1:0] inc_in, inc_out;
    logic [EXTW-1:0]       res_ext;
    logic [IDXW-1:0]       link;
    t_slot                 cs;
    logic                  is_lookup;

    tpc_ram #(.WIDTH(ROWW), .DEPTH(NODE_COUNT)) u_child (
        .i_clk  (i_clk),
        .i_we   (child_we),
        .i_addr (child_addr),
        .i_wdata(child_wdata),
        .o_rdata(child_q)
    );

    tpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODE_COUNT)) u_pass (
        .i_clk  (i_clk),
        .i_we   (pass_we),
        .i_addr (pass_addr),
        .i_wdata(pass_wdata),
        .o_rdata(pass_q)
    );

    tpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODE_COUNT)) u_end (
        .i_clk  (i_clk),
        .i_we   (end_we),
        .i_addr (end_addr),
        .i_wdata(end_wdata),
        .o_rdata(end_q)
    );

    tpc_sat_inc #(.WIDTH(COUNT_BITS)) u_inc (
        .i_val(inc_in),
        .o_val(inc_out)
    );

    assign cs        = letter_slot(r_ch);
    assign link      = child_q[cs.slot*IDXW +: IDXW];
    assign is_lookup = (r_cmd == CMD_WORD) || (r_cmd == CMD_PREFIX);
    assign inc_in    = (r_state == S_END_WR) ? end_q : pass_q;
    assign res_ext   = EXTW'((r_cmd == CMD_WORD) ? end_q : pass_q);

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.count  = r_ocount;
    assign o_out.status = r_ostatus;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_ch      = r_ch;
        n_has     = r_has;
        n_last    = r_last;
        n_started = r_started;
        n_fail    = r_fail;
        n_cur     = r_cur;
        n_used    = r_used;
        n_take    = r_take;
        n_clr     = r_clr;
        n_ovalid  = r_ovalid;
        n_ocount  = r_ocount;
        n_ostatus = r_ostatus;

        child_we    = 1'b0;
        pass_we     = 1'b0;
        end_we      = 1'b0;
        child_addr  = r_cur;
        pass_addr   = r_cur;
        end_addr    = r_cur;
        child_wdata = child_q;
        pass_wdata  = inc_out;
        end_wdata   = inc_out;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                child_we    = 1'b1;
                pass_we     = 1'b1;
                end_we      = 1'b1;
                child_addr  = r_clr;
                pass_addr   = r_clr;
                end_addr    = r_clr;
                child_wdata = '0;
                pass_wdata  = '0;
                end_wdata   = '0;
                n_clr       = r_clr + IDXW'(1);
                if (r_clr == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = i_in.cmd;
                    n_ch    = i_in.ch;
                    n_has   = i_in.has_char;
                    n_last  = i_in.last;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_cmd == CMD_INSERT && !r_started) begin
                    // fetch the root pass count for the word-start bump
                    n_started = 1'b1;
                    pass_addr = '0;
                    n_state   = S_ROOT_WR;
                end else begin
                    n_state = S_CHAR;
                end
            end
            S_ROOT_WR: begin
                pass_we   = 1'b1;
                pass_addr = '0;
                n_state   = S_CHAR;
            end
            S_CHAR: begin
                n_state = S_FINISH;
                if (is_lookup && r_has) begin
                    n_started = 1'b1;
                end
                if (r_has && r_fail == FAIL_NONE && (is_lookup || r_cmd == CMD_INSERT)) begin
                    if (!cs.valid) begin
                        n_fail = FAIL_CHAR;
                    end else begin
                        n_state = S_LINK;
                    end
                end
            end
            S_LINK: begin
                n_state = S_FINISH;
                if (r_cmd == CMD_INSERT) begin
                    if (link == '0) begin
                        if (r_used >= POOL_SIZE) begin
                            n_fail = FAIL_FULL;
                        end else begin
                            // allocate the next free node and hang it on this slot
                            child_we = 1'b1;
                            child_wdata[cs.slot*IDXW +: IDXW] = r_used[IDXW-1:0];
                            pass_addr = r_used[IDXW-1:0];
                            n_cur     = r_used[IDXW-1:0];
                            n_used    = r_used + USEDW'(1);
                            n_state   = S_PASS_WR;
                        end
                    end else begin
                        pass_addr = link;
                        n_cur     = link;
                        n_state   = S_PASS_WR;
                    end
                end else if (link == '0) begin
                    n_fail = FAIL_MISS;
                end else begin
                    n_cur = link;
                end
            end
            S_PASS_WR: begin
                pass_we = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_take = 1'b0;
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_cmd == CMD_INSERT && r_fail == FAIL_NONE) begin
                    n_state = S_END_WR;
                end else begin
                    n_take  = is_lookup && r_started && r_fail == FAIL_NONE;
                    n_state = S_RESULT;
                end
            end
            S_END_WR: begin
                end_we  = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                // hold until the output register is free
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = status_of(r_fail);
                    if (!r_take) begin
                        n_ocount = '0;
                    end else if (res_ext > EXTW'(16'hFFFF)) begin
                        n_ocount = 16'hFFFF;
                    end else begin
                        n_ocount = res_ext[OUT_COUNT_W-1:0];
                    end
                    n_cur     = '0;
                    n_started = 1'b0;
                    n_fail    = FAIL_NONE;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_started <= 1'b0;
            r_fail    <= FAIL_NONE;
            r_cur     <= '0;
            r_used    <= USEDW'(1);
            r_take    <= 1'b0;
            r_clr     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_fail    <= n_fail;
            r_cur     <= n_cur;
            r_used    <= n_used;
            r_take    <= n_take;
            r_clr     <= n_clr;
            r_ovalid  <= n_ovalid;
        end
        r_cmd     <= n_cmd;
        r_ch      <= n_ch;
        r_has     <= n_has;
        r_last    <= n_last;
        r_ocount  <= n_ocount;
        r_ostatus <= n_ostatus;
    end

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) && (r_used <= POOL_SIZE))
        else $error("node pool fill count out of range");

    a_cur_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        USEDW'(r_cur) < r_used)
        else $error("current node is not an allocated node");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_POOL_FULL) |-> (r_used == POOL_SIZE))
        else $error("pool-full status with free nodes left");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_RESULT))
        else $error("result loaded outside the result state");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("clearing sweep left early");
`endif

endmodule

@@ hdl/tpc_ram.sv @@
// ----------------------------------------------------------------------------
// tpc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ hdl/tpc_sat_inc.sv @@
// ----------------------------------------------------------------------------
// tpc_sat_inc
// Saturating incrementer shared by all pass and end count updates.
// ----------------------------------------------------------------------------
module tpc_sat_inc #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0] i_val,
    output logic [WIDTH-1:0] o_val
);

    always_comb begin
        if (&i_val) begin
            o_val = i_val;
        end else begin
            o_val = i_val + WIDTH'(1);
        end
    end

endmodule
